[rtl/core/dltq_pkg.sv]
package dltq_pkg;

	localparam logic [1:0] OP_INSERT  = 2'd0;
	localparam logic [1:0] OP_REMOVE  = 2'd1;
	localparam logic [1:0] OP_ADVANCE = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	localparam logic [1:0] KIND_INS_ACK = 2'd0;
	localparam logic [1:0] KIND_REM_ACK = 2'd1;
	localparam logic [1:0] KIND_FIRED   = 2'd2;
	localparam logic [1:0] KIND_NONE    = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_NOTFOUND = 2'd2;

	localparam int MaxFire = 16;

	// Datapath operation selected by the controller each cycle.
	typedef enum logic [3:0] {
		DP_IDLE,
		DP_LOAD,
		DP_INS_WALK,
		DP_INS_SHIFT,
		DP_INS_FINISH,
		DP_REM_FIND,
		DP_REM_SHIFT,
		DP_ADV_HEAD,
		DP_ADV_POP,
		DP_ADV_SETTLE
	} dp_cmd_t;

	typedef struct packed {
		logic        walk_done;   // insert walk reached its place
		logic        found;       // remove search hit
		logic        search_end;  // remove search ran off the list
		logic        shift_done;
		logic        pop_end;     // closing shift reached the end of the list
		logic        head_due;
		logic        head_more;   // after a pop, the new head fires as well
		logic        no_free;
		logic        busy_h;
		logic [4:0]  fire_cnt;
	} dp_status_t;

endpackage

[rtl/core/dltq_datapath.sv]
module dltq_datapath #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dltq_pkg::dp_cmd_t   cmd,
	input  logic [1:0]          opcode,
	input  logic [31:0]         delay,
	input  logic [15:0]         tag,
	input  logic [3:0]          handle,
	input  logic [31:0]         elapsed,
	output dltq_pkg::dp_status_t st,
	output logic [3:0]          slot_o,
	output logic [15:0]         ftag_o,
	output logic [31:0]         late_o
);
	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [IW-1:0] order_q [QUEUE_DEPTH];
	logic [31:0]   delta_q [QUEUE_DEPTH];
	logic [15:0]   tagm_q  [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] busy_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] idx_q;
	logic [31:0]   rem_q;
	logic [15:0]   tag_q;
	logic [IW-1:0] hnd_q;
	logic          hok_q;
	logic [IW-1:0] free_q;
	logic [4:0]    fire_q;

	logic [IW-1:0] free_c;
	logic          no_free_c;
	logic [IW-1:0] cur_s;
	logic [31:0]   cur_d;
	logic          pos_in;
	logic          hnd_ok;

	always_comb begin
		free_c    = '0;
		no_free_c = 1'b1;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (!busy_q[i]) begin
				free_c    = IW'(i);
				no_free_c = 1'b0;
			end
		end
	end

	assign pos_in = pos_q < count_q;
	assign cur_s  = order_q[pos_q[IW-1:0]];
	assign cur_d  = delta_q[cur_s];
	assign hnd_ok = (32'(handle) < 32'(QUEUE_DEPTH));

	assign st.walk_done  = !pos_in || (cur_d > rem_q);
	assign st.found      = pos_in && (cur_s == hnd_q);
	assign st.search_end = !pos_in;
	assign st.shift_done = (idx_q == pos_q);
	assign st.pop_end    = !(idx_q + 1'b1 < count_q);
	assign st.head_due   = (count_q != '0) && (delta_q[order_q[0]] <= rem_q);
	assign st.head_more  = (count_q > CW'(1)) && (delta_q[order_q[0]] <= rem_q) &&
		(fire_q < 5'(dltq_pkg::MaxFire));
	assign st.no_free    = no_free_c || (count_q >= CW'(QUEUE_DEPTH));
	assign st.busy_h     = hok_q && busy_q[hnd_q];
	assign st.fire_cnt   = fire_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= '0;
			count_q <= '0;
			fire_q  <= '0;
		end else begin
			unique case (cmd)
				dltq_pkg::DP_LOAD: begin
					pos_q  <= '0;
					rem_q  <= (opcode == dltq_pkg::OP_INSERT) ? delay : elapsed;
					tag_q  <= tag;
					hnd_q  <= IW'(handle);
					hok_q  <= hnd_ok;
					free_q <= free_c;
					fire_q <= '0;
				end
				dltq_pkg::DP_INS_WALK: begin
					if (!st.walk_done) begin
						rem_q <= rem_q - cur_d;
						pos_q <= pos_q + 1'b1;
					end else begin
						if (pos_in)
							delta_q[cur_s] <= cur_d - rem_q;
						idx_q <= count_q;
					end
				end
				dltq_pkg::DP_INS_SHIFT: begin
					if (idx_q != pos_q) begin
						order_q[idx_q[IW-1:0]] <= order_q[idx_q[IW-1:0] - 1'b1];
						idx_q <= idx_q - 1'b1;
					end
				end
				dltq_pkg::DP_INS_FINISH: begin
					order_q[pos_q[IW-1:0]] <= free_q;
					delta_q[free_q] <= rem_q;
					tagm_q[free_q]  <= tag_q;
					busy_q[free_q]  <= 1'b1;
					count_q <= count_q + 1'b1;
					slot_o  <= 4'(free_q);
				end
				dltq_pkg::DP_REM_FIND: begin
					if (st.search_end)
						busy_q[hnd_q] <= 1'b0;
					else if (st.found) begin
						if (pos_q + 1'b1 < count_q)
							delta_q[order_q[pos_q[IW-1:0] + 1'b1]] <=
								delta_q[order_q[pos_q[IW-1:0] + 1'b1]] + delta_q[hnd_q];
						idx_q <= pos_q;
					end else
						pos_q <= pos_q + 1'b1;
				end
				dltq_pkg::DP_REM_SHIFT: begin
					if (idx_q + 1'b1 < count_q) begin
						order_q[idx_q[IW-1:0]] <= order_q[idx_q[IW-1:0] + 1'b1];
						idx_q <= idx_q + 1'b1;
					end else begin
						count_q <= count_q - 1'b1;
						busy_q[hnd_q] <= 1'b0;
					end
				end
				dltq_pkg::DP_ADV_HEAD: begin
					// Latch the due head for output, then start to pop it.
					slot_o <= 4'(order_q[0]);
					ftag_o <= tagm_q[order_q[0]];
					late_o <= rem_q - delta_q[order_q[0]];
					rem_q  <= rem_q - delta_q[order_q[0]];
					busy_q[order_q[0]] <= 1'b0;
					fire_q <= fire_q + 1'b1;
					idx_q  <= '0;
				end
				dltq_pkg::DP_ADV_POP: begin
					if (idx_q + 1'b1 < count_q) begin
						order_q[idx_q[IW-1:0]] <= order_q[idx_q[IW-1:0] + 1'b1];
						idx_q <= idx_q + 1'b1;
					end else
						count_q <= count_q - 1'b1;
				end
				dltq_pkg::DP_ADV_SETTLE: begin
					if (count_q != '0)
						delta_q[order_q[0]] <= (delta_q[order_q[0]] <= rem_q) ?
							32'd0 : delta_q[order_q[0]] - rem_q;
				end
				default: ;
			endcase
		end
	end
endmodule

[rtl/core/dltq_ctrl.sv]
module dltq_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           opcode,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           kind,
	output logic [1:0]           status,
	output logic                 fired,
	output logic                 last,
	input  dltq_pkg::dp_status_t st,
	output dltq_pkg::dp_cmd_t    cmd
);
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_DISP  = 4'd1;
	localparam logic [3:0] S_IWALK = 4'd2;
	localparam logic [3:0] S_ISHF  = 4'd3;
	localparam logic [3:0] S_IFIN  = 4'd4;
	localparam logic [3:0] S_RFIND = 4'd5;
	localparam logic [3:0] S_RSHF  = 4'd6;
	localparam logic [3:0] S_ACHK  = 4'd7;
	localparam logic [3:0] S_APOP  = 4'd8;
	localparam logic [3:0] S_AOUT  = 4'd9;
	localparam logic [3:0] S_ASET  = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	logic [3:0] state_q;
	logic [1:0] op_q;
	logic       more_q;  // after the fired result, keep advancing

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT) || (state_q == S_AOUT);
	assign fired     = (state_q == S_AOUT);

	always_comb begin
		cmd = dltq_pkg::DP_IDLE;
		unique case (state_q)
			S_IDLE:  cmd = (in_valid && opcode != dltq_pkg::OP_UNUSED) ?
				dltq_pkg::DP_LOAD : dltq_pkg::DP_IDLE;
			S_IWALK: cmd = dltq_pkg::DP_INS_WALK;
			S_ISHF:  cmd = dltq_pkg::DP_INS_SHIFT;
			S_IFIN:  cmd = dltq_pkg::DP_INS_FINISH;
			S_RFIND: cmd = dltq_pkg::DP_REM_FIND;
			S_RSHF:  cmd = dltq_pkg::DP_REM_SHIFT;
			S_ACHK:  cmd = (st.head_due && st.fire_cnt < 5'(dltq_pkg::MaxFire)) ?
				dltq_pkg::DP_ADV_HEAD : dltq_pkg::DP_IDLE;
			S_APOP:  cmd = dltq_pkg::DP_ADV_POP;
			S_ASET:  cmd = dltq_pkg::DP_ADV_SETTLE;
			default: cmd = dltq_pkg::DP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= '0;
			kind    <= '0;
			status  <= '0;
			last    <= 1'b0;
			more_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && opcode != dltq_pkg::OP_UNUSED) begin
						op_q    <= opcode;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					last   <= 1'b1;
					status <= dltq_pkg::ST_OK;
					if (op_q == dltq_pkg::OP_INSERT) begin
						kind <= dltq_pkg::KIND_INS_ACK;
						if (st.no_free) begin
							status  <= dltq_pkg::ST_FULL;
							state_q <= S_OUT;
						end else
							state_q <= S_IWALK;
					end else if (op_q == dltq_pkg::OP_REMOVE) begin
						kind <= dltq_pkg::KIND_REM_ACK;
						if (!st.busy_h) begin
							status  <= dltq_pkg::ST_NOTFOUND;
							state_q <= S_OUT;
						end else
							state_q <= S_RFIND;
					end else
						state_q <= S_ACHK;
				end
				S_IWALK: if (st.walk_done) state_q <= S_ISHF;
				S_ISHF:  if (st.shift_done) state_q <= S_IFIN;
				S_IFIN:  state_q <= S_OUT;
				S_RFIND: begin
					if (st.search_end) begin
						status  <= dltq_pkg::ST_NOTFOUND;
						state_q <= S_OUT;
					end else if (st.found)
						state_q <= S_RSHF;
				end
				// The pop loops leave when the shift reaches the end of the list.
				S_RSHF: if (st.pop_end) state_q <= S_OUT;
				S_ACHK: begin
					if (cmd == dltq_pkg::DP_ADV_HEAD)
						state_q <= S_APOP;
					else
						state_q <= S_ASET;
				end
				S_APOP: begin
					if (st.pop_end) begin
						kind    <= dltq_pkg::KIND_FIRED;
						status  <= dltq_pkg::ST_OK;
						more_q  <= st.head_more;
						last    <= !st.head_more;
						state_q <= S_AOUT;
					end
				end
				S_ASET: begin
					if (st.fire_cnt == '0) begin
						kind    <= dltq_pkg::KIND_NONE;
						status  <= dltq_pkg::ST_OK;
						last    <= 1'b1;
						state_q <= S_OUT;
					end else
						state_q <= S_IDLE;
				end
				S_AOUT: begin
					if (!out_stall)
						state_q <= more_q ? S_ACHK : S_ASET;
				end
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/core/delta_list_timer_queue_top.sv]
// Delta-list timer queue of QUEUE_DEPTH timers. One transfer in gives one result for
// insert and remove, and for advance one result per fired timer (at most sixteen) or a
// single nothing-due result; opcode three gives none. Items are handled one at a time.
// The controller walks and shifts the ordered list one entry per cycle, and that walk
// sets the timing. An insert result is offered after the walk, shift and finish steps, and
// a remove result after the search and shift; a refused insert or remove answers straight
// from dispatch. An advance offers each fired result after its pop and goes on while the
// new head is due; a nothing-due result comes after the settle step. The next input is
// taken once the last result has left, by way of the settle step after a fired result.
module delta_list_timer_queue_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [31:0] delay,
	input  logic [15:0] tag,
	input  logic [3:0]  handle,
	input  logic [31:0] elapsed,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [1:0]  status,
	output logic [3:0]  slot,
	output logic [15:0] fired_tag,
	output logic [31:0] late_by,
	output logic        last
);
	dltq_pkg::dp_status_t st;
	dltq_pkg::dp_cmd_t    cmd;
	logic        fired;
	logic [3:0]  slot_d;
	logic [15:0] ftag_d;
	logic [31:0] late_d;

	dltq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .opcode, .delay, .tag, .handle, .elapsed,
		.st, .slot_o(slot_d), .ftag_o(ftag_d), .late_o(late_d)
	);

	dltq_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .opcode, .out_valid, .out_stall,
		.kind, .status, .fired, .last, .st, .cmd
	);

	assign slot      = (fired || (kind == dltq_pkg::KIND_INS_ACK && status == dltq_pkg::ST_OK))
		? slot_d : 4'd0;
	assign fired_tag = fired ? ftag_d : 16'd0;
	assign late_by   = fired ? late_d : 32'd0;
endmodule
